>>> rtl/core/mbss_pkg.sv
// Shared types, constants and helper functions for the Modbus battery status sniffer.
package mbss_pkg;

    // Frame layout and protocol constants
    localparam int          REG_COUNT     = 30;
    localparam int          NUM_STAGED    = 10;
    localparam int          NUM_HDR       = 6;
    localparam int          Q_DEPTH       = 2;
    localparam logic [7:0]  DEFAULT_UNIT  = 8'd21;
    localparam logic [15:0] DEFAULT_START = 16'h0190;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'd3;
    localparam logic [7:0]  REQ_LEN       = 8'd8;
    localparam logic [7:0]  MIN_LEN       = 8'd5;
    localparam logic [7:0]  DATA_START    = 8'd3;
    localparam logic [7:0]  RESP_LEN      = 8'(2 * REG_COUNT + 5);
    localparam logic [7:0]  RESP_BYTES    = 8'(2 * REG_COUNT);
    localparam logic [15:0] REG_COUNT_W   = 16'(REG_COUNT);
    localparam logic [7:0]  POS_MAX       = 8'hFF;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // Configuration register indexes
    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] CFG_UNIT_ADDR = 2'd0;
    localparam logic [1:0] CFG_START_ADDR = 2'd1;

    typedef struct packed {
        logic [7:0]  unit_addr;
        logic [15:0] start_addr;
    } cfg_t;

    // One finished frame, as handed from the front end to the judge
    typedef struct packed {
        logic                          crc_ok;
        logic [7:0]                    len;
        logic [NUM_HDR-1:0][7:0]       hdr;
        logic [NUM_STAGED-1:0][15:0]   words;
        logic [31:0]                   stamp;
    } frame_rec_t;

    // One byte through the reflected CRC-16 (poly 0xA001)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Frame byte position of the high byte of each staged data word
    function automatic logic [7:0] word_hi_pos(input logic [3:0] k);
        logic [4:0] w;
        case (k)
            4'd0:    w = 5'd0;
            4'd1:    w = 5'd2;
            4'd2:    w = 5'd3;
            4'd3:    w = 5'd4;
            4'd4:    w = 5'd5;
            4'd5:    w = 5'd12;
            4'd6:    w = 5'd13;
            4'd7:    w = 5'd14;
            4'd8:    w = 5'd16;
            4'd9:    w = 5'd17;
            default: w = 5'd0;
        endcase
        return DATA_START + {2'b00, w, 1'b0};
    endfunction

endpackage

>>> rtl/core/mbss_front.sv
// Byte front end: CRC, position count and capture of header and data bytes.
module mbss_front
    import mbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [31:0] now_ms,
    output logic        push,
    output frame_rec_t  rec
);

    logic [15:0]                 crc_reg;
    logic [7:0]                  pos_reg;
    logic [NUM_HDR-1:0][7:0]     hdr_reg;
    logic [NUM_STAGED-1:0][15:0] words_reg;

    logic [15:0]                 crc_next;
    logic [7:0]                  len_next;
    logic [NUM_HDR-1:0][7:0]     hdr_next;
    logic [NUM_STAGED-1:0][15:0] words_next;

    // Per-byte update; capture stops once the count saturates
    always_comb
    begin
        crc_next   = crc_byte(crc_reg, data_byte);
        hdr_next   = hdr_reg;
        words_next = words_reg;
        len_next   = pos_reg;
        if (pos_reg != POS_MAX)
        begin
            len_next = pos_reg + 8'd1;
            for (int i = 0; i < NUM_HDR; i++)
            begin
                if (pos_reg == 8'(i))
                    hdr_next[i] = data_byte;
            end
            for (int k = 0; k < NUM_STAGED; k++)
            begin
                if (pos_reg == word_hi_pos(4'(k)))
                    words_next[k][15:8] = data_byte;
                if (pos_reg == word_hi_pos(4'(k)) + 8'd1)
                    words_next[k][7:0] = data_byte;
            end
        end
    end

    // Running CRC and count, reloaded after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                crc_reg <= CRC_INIT;
                pos_reg <= '0;
            end
            else
            begin
                crc_reg <= crc_next;
                pos_reg <= len_next;
            end
        end
    end

    // Captured bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg   <= hdr_next;
            words_reg <= words_next;
        end
    end

    // Frame summary goes to the queue on the last beat
    assign push       = accept && frame_end;
    assign rec.crc_ok = (crc_next == 16'h0000);
    assign rec.len    = len_next;
    assign rec.hdr    = hdr_next;
    assign rec.words  = words_next;
    assign rec.stamp  = now_ms;

endmodule

>>> rtl/core/mbss_queue.sv
// Short queue of finished frame summaries between front end and judge.
module mbss_queue
    import mbss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output frame_rec_t head
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    frame_rec_t        slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

>>> rtl/core/mbss_back.sv
// Frame judge: request/response tracking, reading commit and result register.
module mbss_back
    import mbss_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        q_valid,
    input  frame_rec_t                  head,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        accepted,
    output logic                        reading_valid,
    output logic [NUM_STAGED-1:0][15:0] reading_words,
    output logic [31:0]                 reading_time
);

    logic                        out_valid_reg;
    logic                        accepted_reg;
    logic                        await_reg;
    logic                        present_reg;
    logic [NUM_STAGED-1:0][15:0] words_reg;
    logic [31:0]                 time_reg;

    logic frame_ok;
    logic is_request;
    logic req_match;
    logic commit;

    // Result slot frees when empty or taken this cycle
    assign pop = q_valid && (!out_valid_reg || !out_stall);

    // Frame checks
    always_comb
    begin
        frame_ok   = head.crc_ok && (head.len >= MIN_LEN) &&
                     (head.hdr[0] == cfg.unit_addr) && (head.hdr[1] == FUNC_READ_HOLDING);
        is_request = (head.len == REQ_LEN);
        req_match  = ({head.hdr[2], head.hdr[3]} == cfg.start_addr) &&
                     ({head.hdr[4], head.hdr[5]} == REG_COUNT_W);
        commit     = frame_ok && !is_request && await_reg &&
                     (head.len == RESP_LEN) && (head.hdr[2] == RESP_BYTES);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            await_reg     <= 1'b0;
            present_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                accepted_reg  <= commit;
                if (frame_ok)
                    await_reg <= is_request && req_match;
                if (commit)
                    present_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stored reading; only changes when an accepted response enters the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
            time_reg  <= '0;
        end
        else if (pop && commit)
        begin
            words_reg <= head.words;
            time_reg  <= head.stamp;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign reading_valid = present_reg;
    assign reading_words = words_reg;
    assign reading_time  = time_reg;

    a_acc_has_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> present_reg)
        else $error("accepted result without a reading");
    a_commit_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && commit) |=> (!await_reg && out_valid_reg && accepted_reg))
        else $error("commit did not clear wait flag");
    a_commit_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && commit) |-> await_reg)
        else $error("commit without pending request");

endmodule

>>> rtl/core/modbus_battery_status_sniffer.sv
// Top level of the Modbus RTU battery status sniffer.
//
// Input channel: one frame byte per beat (data_byte, frame_end, now_ms) on
// in_valid/in_stall. The last byte of a frame carries frame_end; now_ms is
// used only on that beat. One byte is taken every cycle while in_stall is low.
// Output channel: exactly one result beat per frame end on out_valid/out_stall,
// carrying the accepted flag and the stored reading. The result passes the
// frame queue and then the output register. Per byte the work is one CRC-16
// update and a capture by position, done combinationally in the front end.
// A two-entry frame queue sits between the front end and the judge; in_stall
// rises only when that queue is full, i.e. when results back up behind a
// stalled receiver. A stalled result holds its value.
// Config port: cfg_index 0 = unit address, 1 = status start address; always
// ready; the user must write it only while no frame is in flight (unchecked).
// Reset: CRC 0xFFFF, count zero, no pending request, reading all zero,
// unit address 21, start address 400.
module modbus_battery_status_sniffer
    import mbss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 frame_end,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 accepted,
    output logic                 reading_valid,
    output logic [15:0]          status_word,
    output logic [15:0]          mode_word,
    output logic [15:0]          charge_hundredths,
    output logic [31:0]          capacity_wh,
    output logic [15:0]          voltage_decivolts,
    output logic signed [31:0]   power_w,
    output logic signed [31:0]   internal_power_w,
    output logic [31:0]          measured_at_ms,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t                        cfg_reg;
    logic                        in_accept;
    logic                        q_push;
    logic                        q_full;
    logic                        q_not_empty;
    logic                        q_pop;
    frame_rec_t                  q_in;
    frame_rec_t                  q_head;
    logic [NUM_STAGED-1:0][15:0] rd_words;
    logic [31:0]                 rd_time;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_addr  <= DEFAULT_UNIT;
            cfg_reg.start_addr <= DEFAULT_START;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_UNIT_ADDR:  cfg_reg.unit_addr  <= cfg_data[7:0];
                CFG_START_ADDR: cfg_reg.start_addr <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    mbss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .now_ms    (now_ms),
        .push      (q_push),
        .rec       (q_in)
    );

    mbss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mbss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_not_empty),
        .head          (q_head),
        .pop           (q_pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .accepted      (accepted),
        .reading_valid (reading_valid),
        .reading_words (rd_words),
        .reading_time  (rd_time)
    );

    // Reading fields, big-endian word pairs
    assign status_word       = rd_words[0];
    assign mode_word         = rd_words[1];
    assign charge_hundredths = rd_words[2];
    assign capacity_wh       = {rd_words[3], rd_words[4]};
    assign voltage_decivolts = rd_words[5];
    assign power_w           = {rd_words[6], rd_words[7]};
    assign internal_power_w  = {rd_words[8], rd_words[9]};
    assign measured_at_ms    = rd_time;

endmodule

>>> dv/tb_modbus_battery_status_sniffer.sv
// Self-checking testbench for the Modbus RTU battery status sniffer.
module tb_modbus_battery_status_sniffer;
    import mbss_pkg::*;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // One input beat: a frame byte with its end mark and time stamp
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] stamp;
    } byte_beat_t;

    // One result beat as the block should present it
    typedef struct packed {
        logic        accepted;
        logic        reading_valid;
        logic [15:0] status_word;
        logic [15:0] mode_word;
        logic [15:0] charge_hundredths;
        logic [31:0] capacity_wh;
        logic [15:0] voltage_decivolts;
        logic [31:0] power_w;
        logic [31:0] internal_power_w;
        logic [31:0] measured_at_ms;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'h00;
    logic                 frame_end = 1'b0;
    logic [31:0]          now_ms = 32'h0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 accepted;
    logic                 reading_valid;
    logic [15:0]          status_word;
    logic [15:0]          mode_word;
    logic [15:0]          charge_hundredths;
    logic [31:0]          capacity_wh;
    logic [15:0]          voltage_decivolts;
    logic signed [31:0]   power_w;
    logic signed [31:0]   internal_power_w;
    logic [31:0]          measured_at_ms;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_UNIT_ADDR;
    logic [15:0]          cfg_data = 16'h0;

    modbus_battery_status_sniffer u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .frame_end         (frame_end),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (accepted),
        .reading_valid     (reading_valid),
        .status_word       (status_word),
        .mode_word         (mode_word),
        .charge_hundredths (charge_hundredths),
        .capacity_wh       (capacity_wh),
        .voltage_decivolts (voltage_decivolts),
        .power_w           (power_w),
        .internal_power_w  (internal_power_w),
        .measured_at_ms    (measured_at_ms),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Stimulus and expectation stores
    byte_beat_t  tx_bytes[$];
    reading_t    due_readings[$];
    logic [7:0]  frame_buf[$];
    int          bytes_sent = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 9;
    int          recv_stall_pct = 56;
    logic [7:0]  cur_unit = DEFAULT_UNIT;
    logic [15:0] cur_start = DEFAULT_START;

    // Predictor state: sniffer front end, pending request flag, stored reading
    logic [15:0] crc_acc;
    logic [7:0]  byte_count;
    logic        wait_resp;
    logic [7:0]  hdr_seen [NUM_HDR];
    logic [15:0] staged [NUM_STAGED];
    logic [15:0] held [NUM_STAGED];
    logic [31:0] held_time;
    logic        held_present;
    logic [7:0]  unit_sel;
    logic [15:0] start_sel;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // Which stored word a data word index feeds, or -1
    function automatic int word_slot(input logic [7:0] w);
        case (w)
            8'd0:    return 0;
            8'd2:    return 1;
            8'd3:    return 2;
            8'd4:    return 3;
            8'd5:    return 4;
            8'd12:   return 5;
            8'd13:   return 6;
            8'd14:   return 7;
            8'd16:   return 8;
            8'd17:   return 9;
            default: return -1;
        endcase
    endfunction

    function automatic bit all_drained();
        return tx_bytes.size() == 0 && !in_valid && due_readings.size() == 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Frame assembly: append CRC if asked (optionally damaged), queue as beats
    task automatic send_frame(input bit add_crc, input bit corrupt, input logic [31:0] stamp);
        logic [15:0] crc;
        byte_beat_t  bt;
        crc = CRC_INIT;
        foreach (frame_buf[i])
            crc = crc16_step(crc, frame_buf[i]);
        if (corrupt)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        if (add_crc)
        begin
            frame_buf.push_back(crc[7:0]);
            frame_buf.push_back(crc[15:8]);
        end
        foreach (frame_buf[i])
        begin
            bt.data  = frame_buf[i];
            bt.last  = (i == frame_buf.size() - 1);
            bt.stamp = bt.last ? stamp : $urandom;
            tx_bytes.push_back(bt);
        end
        bytes_sent += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic build_request(input logic [7:0] unit, input logic [7:0] func,
                                 input logic [15:0] start, input logic [15:0] count);
        frame_buf.delete();
        frame_buf.push_back(unit);
        frame_buf.push_back(func);
        frame_buf.push_back(start[15:8]);
        frame_buf.push_back(start[7:0]);
        frame_buf.push_back(count[15:8]);
        frame_buf.push_back(count[7:0]);
    endtask

    task automatic build_response(input logic [7:0] unit, input logic [7:0] func,
                                  input logic [7:0] bcount, input int ndata, input fill_t fill);
        frame_buf.delete();
        frame_buf.push_back(unit);
        frame_buf.push_back(func);
        frame_buf.push_back(bcount);
        for (int i = 0; i < ndata; i++)
        begin
            case (fill)
                FILL_ZERO: frame_buf.push_back(8'h00);
                FILL_ONES: frame_buf.push_back(8'hFF);
                default:   frame_buf.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic good_request();
        build_request(cur_unit, FUNC_READ_HOLDING, cur_start, REG_COUNT_W);
        send_frame(1'b1, 1'b0, $urandom);
    endtask

    task automatic good_response(input fill_t fill, input logic [31:0] stamp);
        build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES, 2 * REG_COUNT, fill);
        send_frame(1'b1, 1'b0, stamp);
    endtask

    // Both registers, back to back; valid stays high across the two beats
    task automatic configure(input logic [7:0] unit, input logic [15:0] start);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_UNIT_ADDR;
        cfg_data  <= {8'($urandom_range(255)), unit};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_START_ADDR;
        cfg_data  <= start;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_unit  = unit;
        cur_start = start;
    endtask

    // Drained, plus slack for the frame queue and output register
    task automatic wait_idle();
        do @(posedge clk); while (!all_drained());
        repeat (8) @(posedge clk);
    endtask

    // Request/response pairs are the largest share; the rest is damaged or stray traffic
    task automatic random_frame();
        int          pick;
        int          sel;
        int          n;
        bit          bad;
        logic [7:0]  u;
        logic [7:0]  f;
        logic [7:0]  bc;
        logic [15:0] s;
        logic [15:0] c;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            good_request();
            good_response(FILL_RANDOM, $urandom);
        end
        else if (pick < 48)
        begin
            good_request();
        end
        else if (pick < 56)
        begin
            good_response(FILL_RANDOM, $urandom);
        end
        else if (pick < 68)
        begin
            // request with one field off
            u = cur_unit;
            f = FUNC_READ_HOLDING;
            s = cur_start;
            c = REG_COUNT_W;
            sel = $urandom_range(3);
            case (sel)
                0:       u = u ^ (8'h01 << $urandom_range(7));
                1:       f = 8'($urandom_range(255));
                2:       s = s ^ (16'h0001 << $urandom_range(15));
                default: c = 16'($urandom);
            endcase
            build_request(u, f, s, c);
            send_frame(1'b1, $urandom_range(9) == 0, $urandom);
        end
        else if (pick < 80)
        begin
            // armed request, then a broken response
            good_request();
            u   = cur_unit;
            bc  = RESP_BYTES;
            n   = 2 * REG_COUNT;
            bad = 1'b0;
            sel = $urandom_range(3);
            case (sel)
                0:       bad = 1'b1;
                1:       n = $urandom_range(1) ? n + 2 : n - 2;
                2:       bc = 8'($urandom_range(255));
                default: u = cur_unit ^ 8'($urandom_range(1, 255));
            endcase
            build_response(u, FUNC_READ_HOLDING, bc, n, FILL_RANDOM);
            send_frame(1'b1, bad, $urandom);
        end
        else if (pick < 98)
        begin
            // short runts and longer noise, header sometimes plausible
            n = (pick < 92) ? $urandom_range(1, 6) : $urandom_range(1, 80);
            frame_buf.delete();
            for (int i = 0; i < n; i++)
                frame_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                frame_buf[0] = cur_unit;
            if (n > 1 && $urandom_range(1))
                frame_buf[1] = FUNC_READ_HOLDING;
            send_frame($urandom_range(1), 1'b0, $urandom);
        end
        else
        begin
            // over-long frame, count saturates
            build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES, $urandom_range(251, 300),
                           FILL_RANDOM);
            send_frame(1'b1, 1'b0, $urandom);
        end
    endtask

    // Driver: input beats from the queue, random sender gaps and receiver stalls
    always @(posedge clk)
    begin
        byte_beat_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (!in_valid || !in_stall)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = tx_bytes.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= nxt.data;
                    frame_end <= nxt.last;
                    now_ms    <= nxt.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on each accepted input beat, checks each result beat
    always @(posedge clk)
    begin
        reading_t   want;
        reading_t   exp_r;
        logic [7:0] off;
        int         slot;
        logic       took;
        if (!rst_n)
        begin
            crc_acc      = CRC_INIT;
            byte_count   = 8'h00;
            wait_resp    = 1'b0;
            held_time    = 32'h0;
            held_present = 1'b0;
            unit_sel     = DEFAULT_UNIT;
            start_sel    = DEFAULT_START;
            for (int i = 0; i < NUM_HDR; i++)
                hdr_seen[i] = 8'h00;
            for (int i = 0; i < NUM_STAGED; i++)
            begin
                staged[i] = 16'h0;
                held[i]   = 16'h0;
            end
            due_readings.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_UNIT_ADDR)
                    unit_sel = cfg_data[7:0];
                else if (cfg_index == CFG_START_ADDR)
                    start_sel = cfg_data;
            end

            // byte intake: CRC always, capture by position until the count sticks
            if (in_valid && !in_stall)
            begin
                crc_acc = crc16_step(crc_acc, data_byte);
                if (byte_count != POS_MAX)
                begin
                    if (byte_count < NUM_HDR)
                        hdr_seen[byte_count] = data_byte;
                    if (byte_count >= DATA_START)
                    begin
                        off  = byte_count - DATA_START;
                        slot = word_slot(off >> 1);
                        if (slot >= 0)
                        begin
                            if (off[0])
                                staged[slot][7:0] = data_byte;
                            else
                                staged[slot][15:8] = data_byte;
                        end
                    end
                    byte_count = byte_count + 8'd1;
                end

                // frame judgement at the last byte
                if (frame_end)
                begin
                    took = 1'b0;
                    if (crc_acc == 16'h0 && byte_count >= MIN_LEN &&
                        hdr_seen[0] == unit_sel && hdr_seen[1] == FUNC_READ_HOLDING)
                    begin
                        if (byte_count == REQ_LEN)
                        begin
                            wait_resp = ({hdr_seen[2], hdr_seen[3]} == start_sel) &&
                                        ({hdr_seen[4], hdr_seen[5]} == REG_COUNT_W);
                        end
                        else
                        begin
                            took = wait_resp && byte_count == RESP_LEN &&
                                   hdr_seen[2] == RESP_BYTES;
                            wait_resp = 1'b0;
                        end
                    end
                    if (took)
                    begin
                        for (int i = 0; i < NUM_STAGED; i++)
                            held[i] = staged[i];
                        held_time    = now_ms;
                        held_present = 1'b1;
                    end
                    exp_r.accepted          = took;
                    exp_r.reading_valid     = held_present;
                    exp_r.status_word       = held[0];
                    exp_r.mode_word         = held[1];
                    exp_r.charge_hundredths = held[2];
                    exp_r.capacity_wh       = {held[3], held[4]};
                    exp_r.voltage_decivolts = held[5];
                    exp_r.power_w           = {held[6], held[7]};
                    exp_r.internal_power_w  = {held[8], held[9]};
                    exp_r.measured_at_ms    = held_time;
                    due_readings.push_back(exp_r);
                    crc_acc    = CRC_INIT;
                    byte_count = 8'h00;
                end
            end

            // result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (due_readings.size() == 0)
                begin
                    report_mismatch("result beat with no frame end pending");
                end
                else
                begin
                    want = due_readings.pop_front();
                    check_field("accepted", accepted, want.accepted);
                    check_field("reading_valid", reading_valid, want.reading_valid);
                    check_field("status_word", status_word, want.status_word);
                    check_field("mode_word", mode_word, want.mode_word);
                    check_field("charge_hundredths", charge_hundredths,
                                want.charge_hundredths);
                    check_field("capacity_wh", capacity_wh, want.capacity_wh);
                    check_field("voltage_decivolts", voltage_decivolts,
                                want.voltage_decivolts);
                    check_field("power_w", power_w, want.power_w);
                    check_field("internal_power_w", internal_power_w, want.internal_power_w);
                    check_field("measured_at_ms", measured_at_ms, want.measured_at_ms);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration; response with no request before it
        good_response(FILL_RANDOM, $urandom);
        // runts: one byte without CRC, four bytes with a good CRC
        frame_buf.push_back(cur_unit);
        send_frame(1'b0, 1'b0, $urandom);
        frame_buf.push_back(cur_unit);
        frame_buf.push_back(FUNC_READ_HOLDING);
        send_frame(1'b1, 1'b0, $urandom);
        // shortest frame that gets judged
        build_response(cur_unit, FUNC_READ_HOLDING, 8'h00, 0, FILL_ZERO);
        send_frame(1'b1, 1'b0, $urandom);
        // full-scale and all-zero readings at the stamp extremes
        good_request();
        good_response(FILL_ONES, 32'hFFFF_FFFF);
        good_request();
        good_response(FILL_ZERO, 32'h0000_0000);
        // bad CRC is dropped and leaves the request armed
        good_request();
        build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES, 2 * REG_COUNT, FILL_RANDOM);
        send_frame(1'b1, 1'b1, $urandom);
        good_response(FILL_RANDOM, $urandom);
        // exception reply, foreign unit, wrong function: all dropped, still armed
        good_request();
        build_response(cur_unit, FUNC_READ_HOLDING | 8'h80, 8'h02, 0, FILL_ZERO);
        send_frame(1'b1, 1'b0, $urandom);
        build_response(cur_unit ^ 8'h01, FUNC_READ_HOLDING, RESP_BYTES, 2 * REG_COUNT,
                       FILL_RANDOM);
        send_frame(1'b1, 1'b0, $urandom);
        build_request(cur_unit, 8'h04, cur_start, REG_COUNT_W);
        send_frame(1'b1, 1'b0, $urandom);
        good_response(FILL_RANDOM, $urandom);
        // request for another start address or count disarms
        build_request(cur_unit, FUNC_READ_HOLDING, cur_start ^ 16'h0001, REG_COUNT_W);
        send_frame(1'b1, 1'b0, $urandom);
        good_response(FILL_RANDOM, $urandom);
        good_request();
        build_request(cur_unit, FUNC_READ_HOLDING, cur_start, REG_COUNT_W + 16'd1);
        send_frame(1'b1, 1'b0, $urandom);
        good_response(FILL_RANDOM, $urandom);
        // wrong byte count field, then wrong length
        good_request();
        build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES - 8'd2, 2 * REG_COUNT,
                       FILL_RANDOM);
        send_frame(1'b1, 1'b0, $urandom);
        good_response(FILL_RANDOM, $urandom);
        good_request();
        build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES, 2 * REG_COUNT - 2,
                       FILL_RANDOM);
        send_frame(1'b1, 1'b0, $urandom);
        // over-long frame: count sticks, CRC covers all of it, request cleared
        good_request();
        build_response(cur_unit, FUNC_READ_HOLDING, RESP_BYTES, 251, FILL_RANDOM);
        send_frame(1'b1, 1'b0, $urandom);
        good_response(FILL_RANDOM, $urandom);
        wait_idle();

        // short segments, new settings and idle pattern per segment;
        // register extremes get a full request/response pair
        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg < 2)
            begin
                send_idle_pct  = 9;
                recv_stall_pct = 56;
            end
            else if (seg < 4)
            begin
                send_idle_pct  = 56;
                recv_stall_pct = 9;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                0:       configure(DEFAULT_UNIT, DEFAULT_START);
                1:       configure(8'h00, 16'h0000);
                3:       configure(8'hFF, 16'hFFFF);
                default: configure(8'($urandom_range(255)), 16'($urandom));
            endcase
            if (seg == 1 || seg == 3)
            begin
                good_request();
                good_response(FILL_RANDOM, $urandom);
            end
            else
            begin
                b0 = bytes_sent;
                while (bytes_sent < b0 + 30)
                    random_frame();
            end
            if (seg < 5)
                wait_idle();
        end

        // final drain, bounded
        for (int w = 0; w < 20000 && !all_drained(); w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (due_readings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_readings.size()));

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
